// ----- rtl/hhp_pkg.sv -----
// Shared types, widths and constants of the heading hold PID unit.
`timescale 1ns / 1ps
`default_nettype none

package hhp_pkg;

	localparam int ANGLE_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 24;
	localparam int DRIVE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int DIFF_W     = ANGLE_W + 1;
	localparam int SUM_W      = LIMIT_W + 1;
	localparam int PROD_E_W   = ANGLE_W + GAIN_W;
	localparam int PROD_I_W   = LIMIT_W + GAIN_W;
	localparam int ACC_W      = PROD_I_W + 2;

	localparam logic signed [DIFF_W-1:0] HALF_TURN = 17'sd18000;
	localparam logic signed [DIFF_W-1:0] FULL_TURN = 17'sd36000;

	localparam logic signed [GAIN_W-1:0]  PROP_GAIN_RST      = 16'sd256;
	localparam logic signed [GAIN_W-1:0]  INT_GAIN_RST       = 16'sd0;
	localparam logic signed [GAIN_W-1:0]  DERIV_GAIN_RST     = 16'sd0;
	localparam logic signed [LIMIT_W-1:0] INTEGRAL_UPPER_RST = 24'sd1000000;
	localparam logic signed [LIMIT_W-1:0] INTEGRAL_LOWER_RST = -24'sd1000000;
	localparam logic signed [DRIVE_W-1:0] DRIVE_UPPER_RST    = 16'sd32767;
	localparam logic signed [DRIVE_W-1:0] DRIVE_LOWER_RST    = -16'sd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INT_GAIN       = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_INTEGRAL_UPPER = 3'd3,
		REG_INTEGRAL_LOWER = 3'd4,
		REG_DRIVE_UPPER    = 3'd5,
		REG_DRIVE_LOWER    = 3'd6
	} hhp_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0]  prop_gain;
		logic signed [GAIN_W-1:0]  int_gain;
		logic signed [GAIN_W-1:0]  deriv_gain;
		logic signed [LIMIT_W-1:0] integral_upper;
		logic signed [LIMIT_W-1:0] integral_lower;
		logic signed [DRIVE_W-1:0] drive_upper;
		logic signed [DRIVE_W-1:0] drive_lower;
	} hhp_cfg_t;

	// Fold an angle difference back into one turn, applied once only.
	function automatic logic signed [DIFF_W-1:0] wrap_once(
		input logic signed [DIFF_W-1:0] a
	);
		logic signed [DIFF_W-1:0] r;
		r = a;
		if (a > HALF_TURN) begin
			r = a - FULL_TURN;
		end else if (a < -HALF_TURN) begin
			r = a + FULL_TURN;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/hhp_cfg_regs.sv -----
// Configuration register file of the heading hold PID unit.
`timescale 1ns / 1ps
`default_nettype none

module hhp_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [hhp_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [hhp_pkg::CFG_DATA_W-1:0]   wr_data,
	output hhp_pkg::hhp_cfg_t                     cfg
);

	hhp_pkg::hhp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= hhp_pkg::PROP_GAIN_RST;
			cfg_q.int_gain       <= hhp_pkg::INT_GAIN_RST;
			cfg_q.deriv_gain     <= hhp_pkg::DERIV_GAIN_RST;
			cfg_q.integral_upper <= hhp_pkg::INTEGRAL_UPPER_RST;
			cfg_q.integral_lower <= hhp_pkg::INTEGRAL_LOWER_RST;
			cfg_q.drive_upper    <= hhp_pkg::DRIVE_UPPER_RST;
			cfg_q.drive_lower    <= hhp_pkg::DRIVE_LOWER_RST;
		end else if (wr_en) begin
			case (wr_index)
				hhp_pkg::REG_PROP_GAIN: begin
					cfg_q.prop_gain <= wr_data[hhp_pkg::GAIN_W-1:0];
				end
				hhp_pkg::REG_INT_GAIN: begin
					cfg_q.int_gain <= wr_data[hhp_pkg::GAIN_W-1:0];
				end
				hhp_pkg::REG_DERIV_GAIN: begin
					cfg_q.deriv_gain <= wr_data[hhp_pkg::GAIN_W-1:0];
				end
				hhp_pkg::REG_INTEGRAL_UPPER: begin
					cfg_q.integral_upper <= wr_data[hhp_pkg::LIMIT_W-1:0];
				end
				hhp_pkg::REG_INTEGRAL_LOWER: begin
					cfg_q.integral_lower <= wr_data[hhp_pkg::LIMIT_W-1:0];
				end
				hhp_pkg::REG_DRIVE_UPPER: begin
					cfg_q.drive_upper <= wr_data[hhp_pkg::DRIVE_W-1:0];
				end
				hhp_pkg::REG_DRIVE_LOWER: begin
					cfg_q.drive_lower <= wr_data[hhp_pkg::DRIVE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/hhp_err.sv -----
// Error stage: wrapped error, wrapped derivative and clamped integral.
`timescale 1ns / 1ps
`default_nettype none

module hhp_err (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire hhp_pkg::hhp_cfg_t                   cfg,
	input  wire logic                                up_valid,
	output logic                                     up_ready,
	input  wire logic signed [hhp_pkg::ANGLE_W-1:0]  tgt_s1,
	input  wire logic signed [hhp_pkg::ANGLE_W-1:0]  meas_s1,
	output logic                                     dn_valid,
	input  wire logic                                dn_ready,
	output logic signed [hhp_pkg::ANGLE_W-1:0]       e_s2,
	output logic signed [hhp_pkg::ANGLE_W-1:0]       d_s2,
	output logic signed [hhp_pkg::LIMIT_W-1:0]       sum_s2
);

	logic signed [hhp_pkg::ANGLE_W-1:0] prev_error_q;
	logic signed [hhp_pkg::LIMIT_W-1:0] error_sum_q;
	logic                               v_s2;

	logic signed [hhp_pkg::DIFF_W-1:0]  diff;
	logic signed [hhp_pkg::DIFF_W-1:0]  e_wide;
	logic signed [hhp_pkg::ANGLE_W-1:0] e;
	logic signed [hhp_pkg::DIFF_W-1:0]  dd;
	logic signed [hhp_pkg::DIFF_W-1:0]  d_wide;
	logic signed [hhp_pkg::SUM_W-1:0]   sum_raw;
	logic signed [hhp_pkg::SUM_W-1:0]   sum_clamped;
	logic                               load;
	logic                               take;

	always_comb begin
		diff   = hhp_pkg::DIFF_W'(tgt_s1) - hhp_pkg::DIFF_W'(meas_s1);
		e_wide = hhp_pkg::wrap_once(diff);
		e      = $signed(e_wide[hhp_pkg::ANGLE_W-1:0]);
		dd     = hhp_pkg::DIFF_W'(e) - hhp_pkg::DIFF_W'(prev_error_q);
		d_wide = hhp_pkg::wrap_once(dd);

		sum_raw = hhp_pkg::SUM_W'(error_sum_q) + hhp_pkg::SUM_W'(e);
		// Upper is checked first; crossed limits give upper above it, else lower.
		if (sum_raw > hhp_pkg::SUM_W'(cfg.integral_upper)) begin
			sum_clamped = hhp_pkg::SUM_W'(cfg.integral_upper);
		end else if (sum_raw < hhp_pkg::SUM_W'(cfg.integral_lower)) begin
			sum_clamped = hhp_pkg::SUM_W'(cfg.integral_lower);
		end else begin
			sum_clamped = sum_raw;
		end
	end

	assign load     = !v_s2 || dn_ready;
	assign take     = up_valid && load;
	assign up_ready = load;
	assign dn_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2         <= 1'b0;
			prev_error_q <= '0;
			error_sum_q  <= '0;
		end else begin
			if (load) begin
				v_s2 <= up_valid;
			end
			if (take) begin
				prev_error_q <= e;
				error_sum_q  <= sum_clamped[hhp_pkg::LIMIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			e_s2   <= e;
			d_s2   <= $signed(d_wide[hhp_pkg::ANGLE_W-1:0]);
			sum_s2 <= sum_clamped[hhp_pkg::LIMIT_W-1:0];
		end
	end

	// A single wrap keeps the error within the full 16-bit input span folded once.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (e_s2 >= -16'sd29535) && (e_s2 <= 16'sd29535))
	else $error("error word left its wrapped range");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (d_s2 >= -16'sd23070) && (d_s2 <= 16'sd23070))
	else $error("derivative word left its wrapped range");

	assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(prev_error_q) && $stable(error_sum_q))
	else $error("controller state changed without an accepted word");

endmodule

`default_nettype wire

// ----- rtl/hhp_mac.sv -----
// Gain products, then sum, floor shift and output saturation.
`timescale 1ns / 1ps
`default_nettype none

module hhp_mac #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire hhp_pkg::hhp_cfg_t                   cfg,
	input  wire logic                                up_valid,
	output logic                                     up_ready,
	input  wire logic signed [hhp_pkg::ANGLE_W-1:0]  e_s2,
	input  wire logic signed [hhp_pkg::ANGLE_W-1:0]  d_s2,
	input  wire logic signed [hhp_pkg::LIMIT_W-1:0]  sum_s2,
	output logic                                     dn_valid,
	input  wire logic                                dn_ready,
	output logic signed [hhp_pkg::DRIVE_W-1:0]       result
);

	logic                                 v_s3;
	logic signed [hhp_pkg::PROD_E_W-1:0]  pe_s3;
	logic signed [hhp_pkg::PROD_I_W-1:0]  pi_s3;
	logic signed [hhp_pkg::PROD_E_W-1:0]  pd_s3;
	logic                                 out_valid_q;
	logic signed [hhp_pkg::DRIVE_W-1:0]   result_q;

	logic                                 load_out;
	logic                                 load_s3;
	logic signed [hhp_pkg::ACC_W-1:0]     acc;
	logic signed [hhp_pkg::ACC_W-1:0]     shifted;
	logic signed [hhp_pkg::ACC_W-1:0]     hi_lim;
	logic signed [hhp_pkg::ACC_W-1:0]     lo_lim;
	logic signed [hhp_pkg::DRIVE_W-1:0]   sat;

	assign load_out = !out_valid_q || dn_ready;
	assign load_s3  = !v_s3 || load_out;
	assign up_ready = load_s3;

	always_comb begin
		acc = hhp_pkg::ACC_W'(pe_s3) + hhp_pkg::ACC_W'(pi_s3) + hhp_pkg::ACC_W'(pd_s3);
		shifted = acc >>> GAIN_FRAC_BITS;
		hi_lim  = hhp_pkg::ACC_W'(cfg.drive_upper);
		lo_lim  = hhp_pkg::ACC_W'(cfg.drive_lower);
		if (shifted > hi_lim) begin
			sat = cfg.drive_upper;
		end else if (shifted < lo_lim) begin
			sat = cfg.drive_lower;
		end else begin
			sat = $signed(shifted[hhp_pkg::DRIVE_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s3) begin
				v_s3 <= up_valid;
			end
			if (load_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3 && up_valid) begin
			pe_s3 <= hhp_pkg::PROD_E_W'(e_s2) * hhp_pkg::PROD_E_W'(cfg.prop_gain);
			pi_s3 <= hhp_pkg::PROD_I_W'(sum_s2) * hhp_pkg::PROD_I_W'(cfg.int_gain);
			pd_s3 <= hhp_pkg::PROD_E_W'(d_s2) * hhp_pkg::PROD_E_W'(cfg.deriv_gain);
		end
		if (load_out && v_s3) begin
			result_q <= sat;
		end
	end

	assign dn_valid = out_valid_q;
	assign result   = result_q;

endmodule

`default_nettype wire

// ----- rtl/heading_hold_pid_unit.sv -----
// Top level of the heading hold PID unit.
`timescale 1ns / 1ps
`default_nettype none

// Heading hold PID controller with a clamped integral and a saturated output.
//
// Input channel (in_valid/in_ready) carries one word per control sample:
// target_angle and measured_angle, signed 0.01 degree units. Output channel
// (out_valid/out_ready) returns one correction word per input word, in order.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the gains and limits; it is always ready, and indexes past the last register
// are dropped. Write it only while no word is in flight.
//
// After the edge that accepts a word into the input register, the word passes
// through the error and integral stage, the product registers, and the sum,
// shift and saturation into the output register, where out_valid rises.
// Throughput is one word per cycle while the receiver keeps up, set by the
// error stage, which updates the previous error and the integral as it takes
// each word, so the next word sees them at once.
//
// Reset clears the controller state (previous error and integral) and loads
// the default gains and limits. When the receiver stalls, each stage holds
// its word and the pipeline keeps accepting until every stage is full; only
// then does in_ready drop.

module heading_hold_pid_unit #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [hhp_pkg::ANGLE_W-1:0]    target_angle,
	input  wire logic signed [hhp_pkg::ANGLE_W-1:0]    measured_angle,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [hhp_pkg::DRIVE_W-1:0]         correction,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [hhp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [hhp_pkg::CFG_DATA_W-1:0]        cfg_data
);

	hhp_pkg::hhp_cfg_t                  cfg;
	logic                               v_s1;
	logic signed [hhp_pkg::ANGLE_W-1:0] tgt_s1;
	logic signed [hhp_pkg::ANGLE_W-1:0] meas_s1;
	logic                               err_ready;
	logic                               err_valid;
	logic                               mac_ready;
	logic signed [hhp_pkg::ANGLE_W-1:0] e_s2;
	logic signed [hhp_pkg::ANGLE_W-1:0] d_s2;
	logic signed [hhp_pkg::LIMIT_W-1:0] sum_s2;
	logic                               load_s1;

	// Registers are always writable; each write is registered in the register file.
	assign cfg_ready = 1'b1;

	hhp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register: the stage frees up whenever the error stage takes its word.
	assign load_s1  = !v_s1 || err_ready;
	assign in_ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			tgt_s1  <= target_angle;
			meas_s1 <= measured_angle;
		end
	end

	hhp_err u_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (v_s1),
		.up_ready (err_ready),
		.tgt_s1   (tgt_s1),
		.meas_s1  (meas_s1),
		.dn_valid (err_valid),
		.dn_ready (mac_ready),
		.e_s2     (e_s2),
		.d_s2     (d_s2),
		.sum_s2   (sum_s2)
	);

	hhp_mac #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (err_valid),
		.up_ready (mac_ready),
		.e_s2     (e_s2),
		.d_s2     (d_s2),
		.sum_s2   (sum_s2),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.result   (correction)
	);

	// Input backpressure only appears once every stage is full behind a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
	else $error("input stalled while the output was free");

endmodule

`default_nettype wire

// ----- verif/heading_hold_pid_unit_test.sv -----
// Self-checking testbench of the heading hold PID unit with its own PID predictor.
`timescale 1ns / 1ps

module heading_hold_pid_unit_test;

	// Bench constants. The pipeline is four stages deep, and the wait after the
	// last correction is sized from that depth so the block is fully quiet.
	localparam int FRAC_BITS    = 8;
	localparam int PIPE_LATENCY = 4;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 90;

	// An index past the last register; the block must drop writes to it.
	localparam logic [hhp_pkg::CFG_IDX_W-1:0] UNMAPPED_REG = 3'd7;

	// Block inputs are all given known values from time zero.
	logic                                clk            = 1'b0;
	logic                                arst_n         = 1'b0;
	logic                                in_valid       = 1'b0;
	logic signed [hhp_pkg::ANGLE_W-1:0]  target_angle   = '0;
	logic signed [hhp_pkg::ANGLE_W-1:0]  measured_angle = '0;
	logic                                out_ready      = 1'b0;
	logic                                cfg_valid      = 1'b0;
	logic [hhp_pkg::CFG_IDX_W-1:0]       cfg_index      = '0;
	logic [hhp_pkg::CFG_DATA_W-1:0]      cfg_data       = '0;
	logic                                in_ready;
	logic                                out_valid;
	logic signed [hhp_pkg::DRIVE_W-1:0]  correction;
	logic                                cfg_ready;

	// Mirror of the controller: its registers, the previous error and the
	// clamped integral, kept in step with every accepted word.
	hhp_pkg::hhp_cfg_t                   ctl_cfg;
	logic signed [hhp_pkg::ANGLE_W-1:0]  prev_err_mirror;
	logic signed [hhp_pkg::LIMIT_W-1:0]  error_integral;

	// Corrections the block still owes us, oldest first.
	logic signed [hhp_pkg::DRIVE_W-1:0]  pending_corrections[$];

	// Handshake pacing: percent of cycles the sender sits idle and the
	// receiver stalls. The hold flag forces a long receiver stall.
	int unsigned                send_idle_pct  = 0;
	int unsigned                recv_stall_pct = 0;
	logic                       hold_active    = 1'b0;

	int unsigned                cycle_count    = 0;
	int unsigned                words_sent     = 0;
	int unsigned                words_checked  = 0;
	int unsigned                mismatch_count = 0;

	heading_hold_pid_unit #(
		.GAIN_FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.target_angle  (target_angle),
		.measured_angle(measured_angle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.correction    (correction),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Every failure goes through here so the final verdict sees it.
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Put the mirror back to its post-reset contents.
	task automatic reset_mirror();
		ctl_cfg.prop_gain      = hhp_pkg::PROP_GAIN_RST;
		ctl_cfg.int_gain       = hhp_pkg::INT_GAIN_RST;
		ctl_cfg.deriv_gain     = hhp_pkg::DERIV_GAIN_RST;
		ctl_cfg.integral_upper = hhp_pkg::INTEGRAL_UPPER_RST;
		ctl_cfg.integral_lower = hhp_pkg::INTEGRAL_LOWER_RST;
		ctl_cfg.drive_upper    = hhp_pkg::DRIVE_UPPER_RST;
		ctl_cfg.drive_lower    = hhp_pkg::DRIVE_LOWER_RST;
		prev_err_mirror        = '0;
		error_integral         = '0;
	endtask

	// Bring a heading difference back into one turn. Only one fold is done,
	// so differences of out-of-range angles may stay outside +-180 degrees.
	function automatic longint fold_turn(input longint a);
		if (a > hhp_pkg::HALF_TURN) begin
			return a - hhp_pkg::FULL_TURN;
		end else if (a < -hhp_pkg::HALF_TURN) begin
			return a + hhp_pkg::FULL_TURN;
		end
		return a;
	endfunction

	// One control step of the predictor. All arithmetic is done in 64-bit
	// integers so the products and their sum are exact; the arithmetic shift
	// of a signed longint rounds toward minus infinity, as the block does.
	function automatic logic signed [hhp_pkg::DRIVE_W-1:0] next_correction(
		input logic signed [hhp_pkg::ANGLE_W-1:0] tgt,
		input logic signed [hhp_pkg::ANGLE_W-1:0] meas
	);
		longint err;
		longint delta;
		longint integ;
		longint acc;
		err   = fold_turn(longint'(tgt) - longint'(meas));
		delta = fold_turn(err - longint'(prev_err_mirror));
		integ = longint'(error_integral) + err;
		// The upper limit is checked first, which decides crossed limits.
		if (integ > longint'($signed(ctl_cfg.integral_upper))) begin
			integ = longint'($signed(ctl_cfg.integral_upper));
		end else if (integ < longint'($signed(ctl_cfg.integral_lower))) begin
			integ = longint'($signed(ctl_cfg.integral_lower));
		end
		error_integral  = integ[hhp_pkg::LIMIT_W-1:0];
		prev_err_mirror = err[hhp_pkg::ANGLE_W-1:0];
		acc = longint'($signed(ctl_cfg.prop_gain)) * err
			+ longint'($signed(ctl_cfg.int_gain)) * integ
			+ longint'($signed(ctl_cfg.deriv_gain)) * delta;
		acc = acc >>> FRAC_BITS;
		if (acc > longint'($signed(ctl_cfg.drive_upper))) begin
			acc = longint'($signed(ctl_cfg.drive_upper));
		end else if (acc < longint'($signed(ctl_cfg.drive_lower))) begin
			acc = longint'($signed(ctl_cfg.drive_lower));
		end
		return acc[hhp_pkg::DRIVE_W-1:0];
	endfunction

	// Offer one word on the input channel. Idle cycles come first, with valid
	// low; once valid is up it stays up until the block takes the word. Valid
	// is left high afterwards so back-to-back words need no extra edge.
	task automatic send_word(
		input logic signed [hhp_pkg::ANGLE_W-1:0] tgt,
		input logic signed [hhp_pkg::ANGLE_W-1:0] meas
	);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		target_angle   <= tgt;
		measured_angle <= meas;
		do begin
			@(posedge clk);
		end while (!in_ready);
		pending_corrections.push_back(next_correction(tgt, meas));
		words_sent++;
	endtask

	// Stop offering words and wait until every correction is back, then let
	// the pipeline run empty. Registers may be written after this.
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_corrections.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_corrections.size() != 0) begin
			report_mismatch($sformatf("%0d corrections never arrived",
				pending_corrections.size()));
			pending_corrections.delete();
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// One register write; the mirror follows once the block has taken it.
	task automatic write_register(
		input logic [hhp_pkg::CFG_IDX_W-1:0]  idx,
		input logic [hhp_pkg::CFG_DATA_W-1:0] data
	);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			hhp_pkg::REG_PROP_GAIN:
				ctl_cfg.prop_gain      = data[hhp_pkg::GAIN_W-1:0];
			hhp_pkg::REG_INT_GAIN:
				ctl_cfg.int_gain       = data[hhp_pkg::GAIN_W-1:0];
			hhp_pkg::REG_DERIV_GAIN:
				ctl_cfg.deriv_gain     = data[hhp_pkg::GAIN_W-1:0];
			hhp_pkg::REG_INTEGRAL_UPPER:
				ctl_cfg.integral_upper = data[hhp_pkg::LIMIT_W-1:0];
			hhp_pkg::REG_INTEGRAL_LOWER:
				ctl_cfg.integral_lower = data[hhp_pkg::LIMIT_W-1:0];
			hhp_pkg::REG_DRIVE_UPPER:
				ctl_cfg.drive_upper    = data[hhp_pkg::DRIVE_W-1:0];
			hhp_pkg::REG_DRIVE_LOWER:
				ctl_cfg.drive_lower    = data[hhp_pkg::DRIVE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sixteen-bit registers only use the low sixteen bits of the data bus, so the
	// upper byte is filled with noise to show that it is ignored.
	function automatic logic [hhp_pkg::CFG_DATA_W-1:0] narrow_data(input int v);
		logic [hhp_pkg::CFG_DATA_W-1:0] d;
		d       = hhp_pkg::CFG_DATA_W'($urandom());
		d[15:0] = v[15:0];
		return d;
	endfunction

	// Write all seven registers in one go.
	task automatic load_settings(input int pg, ig, dg, iu, il, du, dl);
		write_register(hhp_pkg::REG_PROP_GAIN,      narrow_data(pg));
		write_register(hhp_pkg::REG_INT_GAIN,       narrow_data(ig));
		write_register(hhp_pkg::REG_DERIV_GAIN,     narrow_data(dg));
		write_register(hhp_pkg::REG_INTEGRAL_UPPER, iu[hhp_pkg::LIMIT_W-1:0]);
		write_register(hhp_pkg::REG_INTEGRAL_LOWER, il[hhp_pkg::LIMIT_W-1:0]);
		write_register(hhp_pkg::REG_DRIVE_UPPER,    narrow_data(du));
		write_register(hhp_pkg::REG_DRIVE_LOWER,    narrow_data(dl));
	endtask

	// Random settings. Most draws keep the gains near unity and the limits
	// ordered so the output is not pinned at a rail; the rest use the whole
	// register range, which also produces crossed limits.
	task automatic load_random_settings();
		int pg, ig, dg, iu, il, du, dl;
		pg = ($urandom_range(9) < 7) ? int'($urandom_range(1024)) - 512 : int'($urandom());
		ig = ($urandom_range(9) < 7) ? int'($urandom_range(64)) - 32 : int'($urandom());
		dg = ($urandom_range(9) < 7) ? int'($urandom_range(1024)) - 512 : int'($urandom());
		if ($urandom_range(9) < 8) begin
			iu = int'($urandom_range(200000));
			il = -int'($urandom_range(200000));
		end else begin
			iu = $urandom();
			il = $urandom();
		end
		if ($urandom_range(9) < 8) begin
			du = int'($urandom_range(32767));
			dl = -int'($urandom_range(32768));
		end else begin
			du = $urandom();
			dl = $urandom();
		end
		load_settings(pg, ig, dg, iu, il, du, dl);
	endtask

	// Pick one sample. Most samples look like a real heading loop: a target
	// inside the half turn with the measurement close to it. Others spread
	// over the whole half turn, and a few use any 16-bit pattern so that the
	// single fold is exercised with out-of-range angles.
	task automatic pick_angles(
		output logic signed [hhp_pkg::ANGLE_W-1:0] tgt,
		output logic signed [hhp_pkg::ANGLE_W-1:0] meas
	);
		int r;
		int base;
		r    = $urandom_range(99);
		base = int'($urandom_range(36000)) - 18000;
		if (r < 60) begin
			tgt  = hhp_pkg::ANGLE_W'(base);
			meas = hhp_pkg::ANGLE_W'(base + int'($urandom_range(1000)) - 500);
		end else if (r < 85) begin
			tgt  = hhp_pkg::ANGLE_W'(base);
			meas = hhp_pkg::ANGLE_W'(int'($urandom_range(36000)) - 18000);
		end else begin
			tgt  = hhp_pkg::ANGLE_W'($urandom());
			meas = hhp_pkg::ANGLE_W'($urandom());
		end
	endtask

	// Receiver pacing. While a long hold is active, ready stays low no
	// matter what the random stall rate says.
	always @(negedge clk) begin
		out_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
	end

	// Output checker: each correction taken by the receiver is compared with
	// the oldest prediction still waiting.
	always @(posedge clk) begin : check_output
		logic signed [hhp_pkg::DRIVE_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_corrections.size() == 0) begin
				report_mismatch($sformatf("correction %0d with nothing expected",
					correction));
			end else begin
				want = pending_corrections.pop_front();
				words_checked++;
				if (correction !== want) begin
					report_mismatch($sformatf("correction %0d, expected %0d",
						correction, want));
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d corrections waiting",
				cycle_count, pending_corrections.size());
			$display("heading_hold_pid_unit test failed");
			$finish;
		end
	end

	// Reset values: only the unity proportional gain acts, so the correction
	// is the folded error itself. Covers the fold boundaries and angles
	// outside the half turn.
	task automatic test_reset_defaults();
		send_word(16'sd0, 16'sd0);
		send_word(16'sd18000, -16'sd18000);
		send_word(-16'sd18000, 16'sd18000);
		send_word(16'sd17999, -16'sd1);
		send_word(16'sd18000, -16'sd1);
		send_word(16'sd32767, -16'sd32768);
		send_word(-16'sd32768, 16'sd32767);
		settle();
	endtask

	// All three terms at once, with a derivative that folds when the error
	// swings from one end of the turn to the other.
	task automatic test_pid_terms();
		load_settings(640, 128, -384, 1000000, -1000000, 32767, -32768);
		send_word(16'sd9000, -16'sd9000);
		send_word(-16'sd9000, 16'sd9000);
		send_word(16'sd100, 16'sd0);
		send_word(16'sd0, 16'sd100);
		send_word(-16'sd1, 16'sd0);
		settle();
	endtask

	// Integral clamping, first with ordered limits and then with the upper
	// limit below the lower one.
	task automatic test_integral_clamp();
		load_settings(0, 256, 0, 500, -300, 32767, -32768);
		send_word(16'sd400, 16'sd0);
		send_word(16'sd400, 16'sd0);
		send_word(-16'sd18000, 16'sd0);
		send_word(16'sd0, 16'sd0);
		settle();
		write_register(hhp_pkg::REG_INTEGRAL_UPPER, -24'sd100);
		write_register(hhp_pkg::REG_INTEGRAL_LOWER, 24'sd100);
		send_word(16'sd50, 16'sd0);
		send_word(-16'sd50, 16'sd0);
		settle();
	endtask

	// Output saturation, ordered and then crossed.
	task automatic test_drive_saturation();
		load_settings(256, 0, 0, 1000000, -1000000, 1000, -2000);
		send_word(16'sd5000, 16'sd0);
		send_word(-16'sd5000, 16'sd0);
		settle();
		write_register(hhp_pkg::REG_DRIVE_UPPER, narrow_data(-10));
		write_register(hhp_pkg::REG_DRIVE_LOWER, narrow_data(10));
		send_word(16'sd0, 16'sd0);
		send_word(16'sd18000, 16'sd0);
		settle();
	endtask

	// Every register at an end of its range, to catch overflow in the
	// product and sum widths.
	task automatic test_register_extremes();
		load_settings(32767, -32768, 32767, 8388607, -8388608, 32767, -32768);
		send_word(16'sd17000, -16'sd1000);
		send_word(-16'sd18000, 16'sd17999);
		send_word(16'sd32767, -16'sd32768);
		settle();
	endtask

	// A write past the last register must leave every setting as it was.
	task automatic test_unmapped_index();
		load_settings(256, 0, 0, 1000000, -1000000, 32767, -32768);
		write_register(UNMAPPED_REG, 24'hFFFFFF);
		send_word(16'sd1234, -16'sd4321);
		settle();
	endtask

	// Random traffic under one pacing mix, with fresh settings at the start and again halfway.
	task automatic test_random_traffic(
		input int unsigned idle_pct,
		input int unsigned stall_pct,
		input int          count
	);
		logic signed [hhp_pkg::ANGLE_W-1:0] tgt;
		logic signed [hhp_pkg::ANGLE_W-1:0] meas;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if (n % (count / 2) == 0) begin
				settle();
				load_random_settings();
			end
			pick_angles(tgt, meas);
			send_word(tgt, meas);
		end
		settle();
	endtask

	// The receiver stops for a long stretch while the sender keeps pushing,
	// so every pipeline stage fills and in_ready has to drop.
	task automatic test_backpressure();
		logic signed [hhp_pkg::ANGLE_W-1:0] tgt;
		logic signed [hhp_pkg::ANGLE_W-1:0] meas;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		load_random_settings();
		fork
			begin
				@(posedge clk);
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end
		join_none
		for (int n = 0; n < 40; n++) begin
			pick_angles(tgt, meas);
			send_word(tgt, meas);
		end
		settle();
	endtask

	initial begin
		reset_mirror();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_pid_terms();
		test_integral_clamp();
		test_drive_saturation();
		test_register_extremes();
		test_unmapped_index();
		test_random_traffic(0, 0, 140);
		test_random_traffic(84, 0, 140);
		test_random_traffic(0, 84, 140);
		test_random_traffic(15, 15, 140);
		test_backpressure();

		repeat (PIPE_LATENCY * 2) @(posedge clk);
		$display("Sent %0d control words and checked %0d corrections, %0d mismatches.",
			words_sent, words_checked, mismatch_count);
		$display("Covered reset values, each PID term, clamped and crossed limits, %s",
			"register extremes, an unmapped index and four pacing mixes plus a long stall.");
		if (mismatch_count == 0) begin
			$display("heading_hold_pid_unit test passed");
		end else begin
			$display("heading_hold_pid_unit test failed");
		end
		$finish;
	end

endmodule
